FILE: design/cubic_bezier_tessellator_defines.svh
// Assertion helpers for the curve tessellator.
`ifndef CUBIC_BEZIER_TESSELLATOR_DEFINES_SVH
`define CUBIC_BEZIER_TESSELLATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bct_pkg.sv
package bct_pkg;

  localparam int SEG_BITS  = 6;
  localparam int LIMB_BITS = 32;
  localparam logic [SEG_BITS-1:0] SEG_RESET = 6'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WGT,
    ST_MAC
  } bct_state_t;

  // weight sequencer steps
  typedef enum logic [3:0] {
    WS_TT,
    WS_UU,
    WS_TU,
    WS_T3L,
    WS_T3H,
    WS_U3L,
    WS_U3H,
    WS_W1L,
    WS_W1H,
    WS_W2L,
    WS_W2H,
    WS_W2F,
    WS_TRIPLE
  } bct_wstep_t;

  typedef struct packed {
    logic load;
    logic advance;
  } bct_tcmd_t;

  typedef struct packed {
    logic load;
    logic go;
  } bct_lcmd_t;

endpackage

FILE: design/bct_tstep.sv
module bct_tstep #(
  parameter int T_FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bct_pkg::bct_tcmd_t               cmd,
  input  logic [bct_pkg::SEG_BITS-1:0]     seg_n,
  output logic [T_FRACTION_BITS:0]         t,
  output logic                             last,
  output logic                             ready
);
  import bct_pkg::*;

  localparam int TW = T_FRACTION_BITS + 1;
  localparam int CW = $clog2(TW + 1);

  logic [SEG_BITS-1:0] n_r, rem_r, frac_r, idx_r;
  logic [TW-1:0]       q_r, t_r;
  logic [CW-1:0]       cnt_r;
  logic                div_r;
  logic [SEG_BITS:0]   rem_sh, rem_dif, fsum, fdif;
  logic                qbit, wrap;

  // restoring divide of 2^F by n, then step t by quotient and remainder
  always_comb begin
    rem_sh  = {rem_r, (cnt_r == CW'(TW))};
    rem_dif = rem_sh - {1'b0, n_r};
    qbit    = (rem_sh >= {1'b0, n_r});
    fsum    = {1'b0, frac_r} + {1'b0, rem_r};
    fdif    = fsum - {1'b0, n_r};
    wrap    = (fsum >= {1'b0, n_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= SEG_BITS'(1);
      rem_r  <= '0;
      frac_r <= '0;
      idx_r  <= '0;
      q_r    <= '0;
      t_r    <= '0;
      cnt_r  <= '0;
      div_r  <= 1'b0;
    end else if (cmd.load) begin
      n_r    <= seg_n;
      rem_r  <= '0;
      frac_r <= '0;
      idx_r  <= '0;
      q_r    <= '0;
      t_r    <= '0;
      cnt_r  <= CW'(TW);
      div_r  <= 1'b1;
    end else if (div_r) begin
      rem_r <= qbit ? rem_dif[SEG_BITS-1:0] : rem_sh[SEG_BITS-1:0];
      q_r   <= {q_r[TW-2:0], qbit};
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        div_r <= 1'b0;
      end
    end else if (cmd.advance) begin
      t_r    <= t_r + q_r + TW'(wrap);
      frac_r <= wrap ? fdif[SEG_BITS-1:0] : fsum[SEG_BITS-1:0];
      idx_r  <= idx_r + SEG_BITS'(1);
    end
  end

  assign t     = t_r;
  assign last  = (idx_r == n_r);
  assign ready = !div_r;

endmodule

FILE: design/bct_weights.sv
module bct_weights #(
  parameter int T_FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic [T_FRACTION_BITS:0]            t,
  output logic [3:0][3*T_FRACTION_BITS:0]     w,
  output logic                                done
);
  import bct_pkg::*;

  localparam int F  = T_FRACTION_BITS;
  localparam int TW = F + 1;
  localparam int SW = 2 * F + 1;
  localparam int WW = 3 * F + 1;
  localparam logic [TW-1:0] ONE = {1'b1, {F{1'b0}}};

  logic [TW-1:0]   u, mul_a, mul_b;
  logic [2*TW-1:0] prod_r;
  logic [SW-1:0]   tt_r, uu_r, tu_r;
  logic [WW-1:0]   w0_r, w1_r, w2_r, w3_r;
  logic [WW-1:0]   prod_lo, prod_hi;
  bct_wstep_t      step_r;
  logic            run_r, done_r;

  assign u       = ONE - t;
  assign prod_lo = WW'(prod_r);
  assign prod_hi = WW'(prod_r) << TW;

  // one shared multiplier; wide operands go in as low and high halves
  always_comb begin
    mul_a = t;
    mul_b = t;
    unique case (step_r)
      WS_TT:   begin mul_a = t;                     mul_b = t; end
      WS_UU:   begin mul_a = u;                     mul_b = u; end
      WS_TU:   begin mul_a = t;                     mul_b = u; end
      WS_T3L:  begin mul_a = tt_r[TW-1:0];          mul_b = t; end
      WS_T3H:  begin mul_a = {1'b0, tt_r[SW-1:TW]}; mul_b = t; end
      WS_U3L:  begin mul_a = uu_r[TW-1:0];          mul_b = u; end
      WS_U3H:  begin mul_a = {1'b0, uu_r[SW-1:TW]}; mul_b = u; end
      WS_W1L:  begin mul_a = tu_r[TW-1:0];          mul_b = u; end
      WS_W1H:  begin mul_a = {1'b0, tu_r[SW-1:TW]}; mul_b = u; end
      WS_W2L:  begin mul_a = tu_r[TW-1:0];          mul_b = t; end
      WS_W2H:  begin mul_a = {1'b0, tu_r[SW-1:TW]}; mul_b = t; end
      default: begin mul_a = t;                     mul_b = t; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= WS_TT;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        step_r <= WS_TT;
      end else if (run_r) begin
        if (step_r == WS_TRIPLE) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= bct_wstep_t'(step_r + 4'd1);
        end
      end
    end
  end

  // steps WS_UU to WS_W2F each consume the registered product of the step before
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (run_r) begin
      case (step_r)
        WS_UU:     tt_r <= prod_r[SW-1:0];
        WS_TU:     uu_r <= prod_r[SW-1:0];
        WS_T3L:    tu_r <= prod_r[SW-1:0];
        WS_T3H:    w3_r <= prod_lo;
        WS_U3L:    w3_r <= w3_r + prod_hi;
        WS_U3H:    w0_r <= prod_lo;
        WS_W1L:    w0_r <= w0_r + prod_hi;
        WS_W1H:    w1_r <= prod_lo;
        WS_W2L:    w1_r <= w1_r + prod_hi;
        WS_W2H:    w2_r <= prod_lo;
        WS_W2F:    w2_r <= w2_r + prod_hi;
        WS_TRIPLE: begin
          w1_r <= w1_r + (w1_r << 1);
          w2_r <= w2_r + (w2_r << 1);
        end
        default: ;
      endcase
    end
  end

  assign w[0] = w0_r;
  assign w[1] = w1_r;
  assign w[2] = w2_r;
  assign w[3] = w3_r;
  assign done = done_r;

endmodule

FILE: design/bct_lane.sv
module bct_lane #(
  parameter int COORD_BITS      = 16,
  parameter int T_FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bct_pkg::bct_lcmd_t                  cmd,
  input  logic [3:0][COORD_BITS-1:0]          pts,
  input  logic [3:0][3*T_FRACTION_BITS:0]     w,
  output logic [COORD_BITS-1:0]               coord,
  output logic                                done
);
  import bct_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int SHIFT = 3 * T_FRACTION_BITS;
  localparam int LB    = LIMB_BITS;
  localparam int NA    = (SHIFT + C + LB - 1) / LB;
  localparam int AW    = NA * LB;
  localparam int LIW   = (NA > 1) ? $clog2(NA) : 1;
  localparam logic [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (SHIFT - 1);
  localparam logic [C-1:0]  SIGN = {1'b1, {(C-1){1'b0}}};
  localparam logic [LIW-1:0] LAST_LIMB = LIW'(NA - 1);
  localparam logic [1:0]     LAST_TERM = 2'd3;

  logic [3:0][C-1:0] pts_r;
  logic [AW-1:0]     acc_r, acc_nxt, wpad;
  logic [C:0]        carry_r, carry_nxt;
  logic [1:0]        term_r;
  logic [LIW-1:0]    limb_r;
  logic              run_r, done_r;
  logic [LB-1:0]     wl, al;
  logic [LB+C-1:0]   mprod;
  logic [LB+C:0]     sum;

  // one limb of weight times point, added into the accumulator with carry
  always_comb begin
    wpad      = AW'(w[term_r]);
    wl        = wpad[limb_r*LB +: LB];
    al        = acc_r[limb_r*LB +: LB];
    mprod     = wl * pts_r[term_r];
    sum       = {1'b0, mprod} + {{(C+1){1'b0}}, al} + {{LB{1'b0}}, carry_r};
    acc_nxt   = acc_r;
    acc_nxt[limb_r*LB +: LB] = sum[LB-1:0];
    carry_nxt = sum[LB+C:LB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      term_r <= '0;
      limb_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.go) begin
        run_r  <= 1'b1;
        term_r <= '0;
        limb_r <= '0;
      end else if (run_r) begin
        if (limb_r == LAST_LIMB) begin
          limb_r <= '0;
          term_r <= term_r + 2'd1;
          if (term_r == LAST_TERM) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end
        end else begin
          limb_r <= limb_r + LIW'(1);
        end
      end
    end
  end

  // points held as offset binary so every product is unsigned
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 4; k++) begin
        pts_r[k] <= pts[k] ^ SIGN;
      end
    end
    if (cmd.go) begin
      acc_r   <= HALF;
      carry_r <= '0;
    end else if (run_r) begin
      acc_r   <= acc_nxt;
      carry_r <= (limb_r == LAST_LIMB) ? '0 : carry_nxt;
    end
  end

  assign coord = acc_r[SHIFT +: C] ^ SIGN;
  assign done  = done_r;

endmodule

FILE: design/cubic_bezier_tessellator.sv
// Channel   Handshake                   Beat contents
// --------  --------------------------  ------------------------------------------
// in        start & !busy               p1..p4 control points, x/y/z each
// out       out_valid (one-cycle pulse) out_vertex_x/y/z, out_is_last
// cfg       cfg_valid & cfg_ready       cfg_data = segment count
//
// A curve first divides 2^F by the segment count n (one quotient bit a cycle),
// then each vertex takes 13 steps of the shared weight multiplier plus
// 4*NA limb passes in the lanes, with NA = ceil((3*F + COORD_BITS) / 32).
// Synchronous active-low reset restores a segment count of 16 and idles.
// Out beats cannot be stalled; busy holds off start for the whole curve.
`include "cubic_bezier_tessellator_defines.svh"

module cubic_bezier_tessellator #(
  parameter int COORD_BITS      = 16,
  parameter int T_FRACTION_BITS = 16,
  parameter int MAX_SEGMENTS    = 63
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_BITS-1:0]       in_p1_x,
  input  logic signed [COORD_BITS-1:0]       in_p1_y,
  input  logic signed [COORD_BITS-1:0]       in_p1_z,
  input  logic signed [COORD_BITS-1:0]       in_p2_x,
  input  logic signed [COORD_BITS-1:0]       in_p2_y,
  input  logic signed [COORD_BITS-1:0]       in_p2_z,
  input  logic signed [COORD_BITS-1:0]       in_p3_x,
  input  logic signed [COORD_BITS-1:0]       in_p3_y,
  input  logic signed [COORD_BITS-1:0]       in_p3_z,
  input  logic signed [COORD_BITS-1:0]       in_p4_x,
  input  logic signed [COORD_BITS-1:0]       in_p4_y,
  input  logic signed [COORD_BITS-1:0]       in_p4_z,
  output logic                               out_valid,
  output logic signed [COORD_BITS-1:0]       out_vertex_x,
  output logic signed [COORD_BITS-1:0]       out_vertex_y,
  output logic signed [COORD_BITS-1:0]       out_vertex_z,
  output logic                               out_is_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bct_pkg::SEG_BITS-1:0]       cfg_data
);
  import bct_pkg::*;

  localparam int WW = 3 * T_FRACTION_BITS + 1;
  localparam logic [SEG_BITS-1:0] MAX_N = SEG_BITS'(MAX_SEGMENTS);

  bct_state_t state_r, state_nxt;
  bct_tcmd_t  tcmd;
  bct_lcmd_t  lcmd;
  logic       w_go, emit;

  logic [SEG_BITS-1:0]   seg_r, seg_n;
  logic [T_FRACTION_BITS:0] t_val;
  logic                  t_last, t_ready;
  logic [3:0][WW-1:0]    weights;
  logic                  w_done;

  logic [2:0][3:0][COORD_BITS-1:0] lane_pts;
  logic [2:0][COORD_BITS-1:0]      lane_coord;
  logic [2:0]                      lane_done;
  logic                            out_valid_r;

  // Segment count register; writes land whenever offered, the run snapshots
  // the sanitized count at accept.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seg_r <= cfg_data;
    end
  end

  // Zero acts as one segment; clamp to the configured ceiling.
  always_comb begin
    if (seg_r == '0) begin
      seg_n = SEG_BITS'(1);
    end else if (seg_r > MAX_N) begin
      seg_n = MAX_N;
    end else begin
      seg_n = seg_r;
    end
  end

  // Parameter t generator: divides once per curve, then steps per vertex.
  bct_tstep #(
    .T_FRACTION_BITS (T_FRACTION_BITS)
  ) u_tstep (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (tcmd),
    .seg_n (seg_n),
    .t     (t_val),
    .last  (t_last),
    .ready (t_ready)
  );

  // Bernstein weights, shared by all three lanes.
  bct_weights #(
    .T_FRACTION_BITS (T_FRACTION_BITS)
  ) u_weights (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (w_go),
    .t     (t_val),
    .w     (weights),
    .done  (w_done)
  );

  // One lane per axis; index 0 of each point set is P1.
  assign lane_pts[0] = {in_p4_x, in_p3_x, in_p2_x, in_p1_x};
  assign lane_pts[1] = {in_p4_y, in_p3_y, in_p2_y, in_p1_y};
  assign lane_pts[2] = {in_p4_z, in_p3_z, in_p2_z, in_p1_z};

  for (genvar a = 0; a < 3; a++) begin : g_lane
    bct_lane #(
      .COORD_BITS      (COORD_BITS),
      .T_FRACTION_BITS (T_FRACTION_BITS)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (lcmd),
      .pts   (lane_pts[a]),
      .w     (weights),
      .coord (lane_coord[a]),
      .done  (lane_done[a])
    );
  end

  // Sequencer: divide, then alternate weights and lane passes per vertex.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_DIV;
      ST_DIV:  if (t_ready) state_nxt = ST_WGT;
      ST_WGT:  if (w_done) state_nxt = ST_MAC;
      ST_MAC:  if (lane_done[0]) state_nxt = t_last ? ST_IDLE : ST_WGT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    tcmd = '0;
    lcmd = '0;
    w_go = 1'b0;
    emit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          tcmd.load = 1'b1;
          lcmd.load = 1'b1;
        end
      end
      ST_DIV: begin
        w_go = t_ready;
      end
      ST_WGT: begin
        lcmd.go = w_done;
      end
      ST_MAC: begin
        if (lane_done[0]) begin
          emit = 1'b1;
          // advance t and restart the weights for the next vertex
          tcmd.advance = !t_last;
          w_go         = !t_last;
        end
      end
      default: ;
    endcase
  end

  // Merge the three lane results into one out beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_vertex_x <= lane_coord[0];
      out_vertex_y <= lane_coord[1];
      out_vertex_z <= lane_coord[2];
      out_is_last  <= t_last;
    end
  end

  assign out_valid = out_valid_r;
  assign busy      = (state_r != ST_IDLE);

  `BCT_ASSERT_IMP(a_lanes_lockstep, clk, rst_n, lane_done[0], lane_done[1] && lane_done[2], "axis lanes out of step")
  `BCT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "no busy after accept")
  `BCT_ASSERT_IMP(a_last_idle, clk, rst_n, out_valid && out_is_last, state_r == ST_IDLE, "last beat but still running")
  `BCT_ASSERT_IMP(a_go_weights, clk, rst_n, lcmd.go, w_done && t_ready, "lane start without weights")

endmodule

FILE: sim/cubic_bezier_tessellator_tb.sv
`timescale 1ns / 100ps

module cubic_bezier_tessellator_tb;
  import bct_pkg::*;

  localparam int CW = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  // Idle long enough after the drain to catch a stray vertex.
  localparam int TAIL_CYCLES = 100;
  localparam int RAND_PHASES = 8;
  localparam int CURVES_PER_PHASE = 12;
  localparam logic [CW-1:0] COORD_MIN = 16'h8000;
  localparam logic [CW-1:0] COORD_MAX = 16'h7FFF;
  localparam logic [CW-1:0] COORD_ZERO = 16'h0000;
  localparam logic [CW-1:0] COORD_NEG1 = 16'hFFFF;

  // Control points: index [point P1..P4][axis x,y,z].
  typedef logic [3:0][2:0][CW-1:0] ctrl_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic          last;
  } vertex_t;

  // Predicts the vertex run of each accepted curve and checks arriving vertices in order.
  class vertex_checker;
    logic [SEG_BITS-1:0] seg_count;
    vertex_t             vertex_q[$];
    int                  errors;

    function new();
      seg_count = SEG_RESET;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    // Bernstein blend of one vertex; all products exact in 128 bits, then round half up.
    function vertex_t bezier_vertex(input ctrl_t c, input int unsigned i, input int unsigned n);
      logic signed [127:0] tw, uw, acc, pv;
      logic signed [127:0] w[4];
      logic [CW-1:0]       r[3];
      vertex_t             v;
      tw = $signed(128'((i << 16) / n));
      uw = (128'sd1 <<< 16) - tw;
      w[0] = uw * uw * uw;
      w[1] = 3 * tw * uw * uw;
      w[2] = 3 * tw * tw * uw;
      w[3] = tw * tw * tw;
      for (int a = 0; a < 3; a++) begin
        acc = 128'sd1 <<< 47;
        for (int k = 0; k < 4; k++) begin
          pv = $signed(c[k][a]);
          acc = acc + w[k] * pv;
        end
        acc = acc >>> 48;
        r[a] = acc[CW-1:0];
      end
      v.x = r[0];
      v.y = r[1];
      v.z = r[2];
      v.last = (i == n);
      return v;
    endfunction

    function void note_curve(input ctrl_t c);
      int unsigned n;
      // A zero count runs as a single segment; six bits cannot exceed the maximum.
      n = (seg_count == 0) ? 1 : seg_count;
      for (int unsigned i = 0; i <= n; i++)
        vertex_q = {vertex_q, bezier_vertex(c, i, n)};
    endfunction

    task check_vertex(input vertex_t got);
      vertex_t want;
      if (vertex_q.size() == 0) begin
        report($sformatf("vertex %h/%h/%h with no curve pending", got.x, got.y, got.z));
        return;
      end
      want = vertex_q.pop_front();
      if (got.x !== want.x)
        report($sformatf("vertex_x got %h want %h", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("vertex_y got %h want %h", got.y, want.y));
      if (got.z !== want.z)
        report($sformatf("vertex_z got %h want %h", got.z, want.z));
      if (got.last !== want.last)
        report($sformatf("is_last got %b want %b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [CW-1:0] in_p1_x, in_p1_y, in_p1_z;
  logic signed [CW-1:0] in_p2_x, in_p2_y, in_p2_z;
  logic signed [CW-1:0] in_p3_x, in_p3_y, in_p3_z;
  logic signed [CW-1:0] in_p4_x, in_p4_y, in_p4_z;
  logic out_valid;
  logic signed [CW-1:0] out_vertex_x, out_vertex_y, out_vertex_z;
  logic out_is_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [SEG_BITS-1:0] cfg_data;

  vertex_checker board;
  int cycle_count;

  cubic_bezier_tessellator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_p1_x      (in_p1_x),
    .in_p1_y      (in_p1_y),
    .in_p1_z      (in_p1_z),
    .in_p2_x      (in_p2_x),
    .in_p2_y      (in_p2_y),
    .in_p2_z      (in_p2_z),
    .in_p3_x      (in_p3_x),
    .in_p3_y      (in_p3_y),
    .in_p3_z      (in_p3_z),
    .in_p4_x      (in_p4_x),
    .in_p4_y      (in_p4_y),
    .in_p4_z      (in_p4_z),
    .out_valid    (out_valid),
    .out_vertex_x (out_vertex_x),
    .out_vertex_y (out_vertex_y),
    .out_vertex_z (out_vertex_z),
    .out_is_last  (out_is_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Sample the vertex beat at the edge that ends its one-cycle pulse; the block
  // cannot be stalled, so every strobe is a beat. Also bound the run length.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_vertex('{x: out_vertex_x, y: out_vertex_y, z: out_vertex_z,
                           last: out_is_last});
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("cubic_bezier_tessellator_tb failed");
      $finish;
    end
  end

  // Put one curve on the ports, hold start until the block takes it, then note it.
  // Leave start high on return; the caller drops it when it idles or drains.
  task automatic send_curve(input ctrl_t c);
    start   <= 1'b1;
    in_p1_x <= c[0][0];
    in_p1_y <= c[0][1];
    in_p1_z <= c[0][2];
    in_p2_x <= c[1][0];
    in_p2_y <= c[1][1];
    in_p2_z <= c[1][2];
    in_p3_x <= c[2][0];
    in_p3_y <= c[2][1];
    in_p3_z <= c[2][2];
    in_p4_x <= c[3][0];
    in_p4_y <= c[3][1];
    in_p4_z <= c[3][2];
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_curve(c);
  endtask

  // Drop start and hold until every predicted vertex has arrived and the block is idle.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (board.vertex_q.size() != 0 || busy) @(posedge clk);
  endtask

  // Write the segment count; only called while the block is idle.
  task automatic write_segments(input logic [SEG_BITS-1:0] n);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.seg_count = n;
  endtask

  // Same point on every axis: handy for hull extremes.
  function automatic ctrl_t flat_ctrl(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                      input logic [CW-1:0] c, input logic [CW-1:0] d);
    ctrl_t r;
    for (int ax = 0; ax < 3; ax++) begin
      r[0][ax] = a;
      r[1][ax] = b;
      r[2][ax] = c;
      r[3][ax] = d;
    end
    return r;
  endfunction

  // Random coordinates, with the extremes, zero and minus one mixed in often.
  function automatic ctrl_t rand_ctrl();
    ctrl_t r;
    for (int k = 0; k < 4; k++)
      for (int ax = 0; ax < 3; ax++)
        case ($urandom_range(0, 9))
          0: r[k][ax] = COORD_MIN;
          1: r[k][ax] = COORD_MAX;
          2: r[k][ax] = COORD_ZERO;
          3: r[k][ax] = COORD_NEG1;
          default: r[k][ax] = CW'($urandom);
        endcase
    return r;
  endfunction

  initial begin
    int idle_pct;
    ctrl_t mixed;
    board = new();
    cycle_count = 0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_p1_x <= '0; in_p1_y <= '0; in_p1_z <= '0;
    in_p2_x <= '0; in_p2_y <= '0; in_p2_z <= '0;
    in_p3_x <= '0; in_p3_y <= '0; in_p3_z <= '0;
    in_p4_x <= '0; in_p4_y <= '0; in_p4_z <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: run at the reset count of 16 first, then walk the count through
    // zero (runs as one segment), the maximum, one and three.
    mixed = flat_ctrl(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    mixed[0][1] = COORD_MAX;
    mixed[3][1] = COORD_MIN;
    mixed[1][2] = COORD_NEG1;
    mixed[2][2] = 16'h0001;
    send_curve(flat_ctrl(COORD_ZERO, COORD_ZERO, COORD_ZERO, COORD_ZERO));
    send_curve(flat_ctrl(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_curve(flat_ctrl(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_curve(flat_ctrl(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    send_curve(flat_ctrl(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
    send_curve(mixed);
    send_curve(flat_ctrl(COORD_NEG1, 16'h0001, COORD_NEG1, 16'h0001));
    wait_drained();

    write_segments(6'd0);
    send_curve(flat_ctrl(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
    send_curve(mixed);
    send_curve(rand_ctrl());
    wait_drained();

    write_segments(6'd63);
    send_curve(flat_ctrl(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    send_curve(mixed);
    wait_drained();

    write_segments(6'd1);
    send_curve(flat_ctrl(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
    send_curve(rand_ctrl());
    wait_drained();

    write_segments(6'd3);
    send_curve(flat_ctrl(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
    send_curve(rand_ctrl());
    wait_drained();

    // Random phases: rotate the sender's idle rate and pick a segment count per
    // phase, mostly small so the long runs stay rare. The block cannot stall its
    // output, so only the sender side idles.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        1: idle_pct = 86;
        3: idle_pct = 26;
        default: idle_pct = 0;
      endcase
      case (ph)
        3: write_segments(6'd63);
        5: write_segments(SEG_BITS'($urandom_range(9, 62)));
        6: write_segments(6'd1);
        default: write_segments(SEG_BITS'($urandom_range(0, 8)));
      endcase
      for (int j = 0; j < CURVES_PER_PHASE; j++) begin
        // Now and then hold the next curve back until the block has drained.
        if ($urandom_range(0, 15) == 0)
          wait_drained();
        while ($urandom_range(1, 100) <= idle_pct) begin
          start <= 1'b0;
          @(posedge clk);
        end
        send_curve(rand_ctrl());
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.vertex_q.size() == 0) begin
      $display("cubic_bezier_tessellator_tb passed");
    end else begin
      $display("cubic_bezier_tessellator_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/bct_pkg.sv
design/bct_tstep.sv
design/bct_weights.sv
design/bct_lane.sv
design/cubic_bezier_tessellator.sv
sim/cubic_bezier_tessellator_tb.sv
